@@ src/ttds_pkg.sv @@
// ----------------------------------------------------------------------------
// ttds_pkg
// Shared types and constants of the touch tap detector and scaler.
// ----------------------------------------------------------------------------
package ttds_pkg;

    localparam int VAL_W   = 32;
    localparam int SIZE_W  = 12;
    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 5;
    localparam int PROD_W  = VAL_W + SIZE_W;
    localparam int CNT_W   = 6;

    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(SIZE_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

    localparam logic [VAL_W-1:0]  RST_RAW_MIN = 32'd0;
    localparam logic [VAL_W-1:0]  RST_RAW_MAX = 32'd4095;
    localparam logic [SIZE_W-1:0] RST_WIDTH   = 12'd1200;
    localparam logic [SIZE_W-1:0] RST_HEIGHT  = 12'd1600;

    typedef enum logic [CMD_W-1:0] {
        CMD_POS_X   = 3'd0,
        CMD_POS_Y   = 3'd1,
        CMD_CONTACT = 3'd2,
        CMD_BUTTON  = 3'd3,
        CMD_SYNC    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        REG_RAW_MIN_X     = 3'd0,
        REG_RAW_MAX_X     = 3'd1,
        REG_RAW_MIN_Y     = 3'd2,
        REG_RAW_MAX_Y     = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5
    } t_reg;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_ABS  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

endpackage

@@ src/touch_tap_detector_scaler_unit.sv @@
// ----------------------------------------------------------------------------
// touch_tap_detector_scaler_unit
// Tracks touch events and emits a screen-scaled tap on each release sync.
// ----------------------------------------------------------------------------
// Events are taken one word at a time. Position, contact and button events
// are registered when taken. A sync that sees a release (down at the previous
// sync, up now) scales X and then Y through one shared bit-serial unit: per
// axis the setup states PREP and ABS, a shift-add multiply, a restoring divide
// and a sign step in FIN; the tap word then waits in OUT while the previous
// tap word is still waiting on the output, and no event is taken
// meanwhile. Scaling is (raw - min) * size / (max - min), truncated toward
// zero and wrapped to 32 bits; a span of zero or less counts as 1.
// ----------------------------------------------------------------------------
module touch_tap_detector_scaler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] event_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] tap_x, [63:32] tap_y
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ttds_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = ttds_pkg::VAL_W;
    localparam int SW = ttds_pkg::SIZE_W;
    localparam int PW = ttds_pkg::PROD_W;
    localparam int CW = ttds_pkg::CNT_W;

    logic [VW-1:0] r_raw_min_x, r_raw_max_x, r_raw_min_y, r_raw_max_y;
    logic [SW-1:0] r_screen_width, r_screen_height;
    logic [VW-1:0] r_last_x, r_last_y;
    logic          r_contact, r_down_sync;

    ttds_pkg::t_state r_state, n_state;
    logic          r_axis, n_axis;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [VW-1:0] r_diff, n_diff;
    logic [VW-1:0] r_span, n_span;
    logic [VW-1:0] r_mag, n_mag;
    logic          r_neg, n_neg;
    logic [VW-2:0] r_dvs, n_dvs;
    logic [SW-1:0] r_size, n_size;
    logic [PW-1:0] r_acc, n_acc;
    logic [VW-1:0] r_rem, n_rem;
    logic [VW-1:0] r_qx, n_qx;
    logic [VW-1:0] r_qy, n_qy;
    logic [VW-1:0] r_out_x, r_out_y;
    logic          r_out_valid;

    logic          w_in_acc, w_cfg_wr, w_out_load;
    logic [VW-1:0] w_raw, w_lo, w_hi, w_q;
    logic [SW-1:0] w_size;
    logic [VW:0]   w_trial;
    logic          w_qbit;
    logic          w_release;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == ttds_pkg::ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_wr      = psel && penable && pwrite && pready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_y, r_out_x};
    assign w_release     = r_down_sync && !r_contact;
    assign w_out_load    = (r_state == ttds_pkg::ST_OUT) && (!r_out_valid || m_axis_tready);

    assign w_raw  = r_axis ? r_last_y        : r_last_x;
    assign w_lo   = r_axis ? r_raw_min_y     : r_raw_min_x;
    assign w_hi   = r_axis ? r_raw_max_y     : r_raw_max_x;
    assign w_size = r_axis ? r_screen_height : r_screen_width;

    assign w_trial = {1'b0, r_rem[VW-2:0], r_acc[PW-1]} - {2'b00, r_dvs};
    assign w_qbit  = !w_trial[VW];
    assign w_q     = r_neg ? (~r_acc[VW-1:0] + VW'(1)) : r_acc[VW-1:0];

    always_comb begin
        prdata = '0;
        unique case (ttds_pkg::t_reg'(paddr[4:2]))
            ttds_pkg::REG_RAW_MIN_X:     prdata = r_raw_min_x;
            ttds_pkg::REG_RAW_MAX_X:     prdata = r_raw_max_x;
            ttds_pkg::REG_RAW_MIN_Y:     prdata = r_raw_min_y;
            ttds_pkg::REG_RAW_MAX_Y:     prdata = r_raw_max_y;
            ttds_pkg::REG_SCREEN_WIDTH:  prdata = {{(32-SW){1'b0}}, r_screen_width};
            ttds_pkg::REG_SCREEN_HEIGHT: prdata = {{(32-SW){1'b0}}, r_screen_height};
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        n_diff  = r_diff;
        n_span  = r_span;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_dvs   = r_dvs;
        n_size  = r_size;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_qx    = r_qx;
        n_qy    = r_qy;
        unique case (r_state)
            ttds_pkg::ST_IDLE: begin
                if (w_in_acc && ttds_pkg::t_cmd'(s_axis_tuser) == ttds_pkg::CMD_SYNC
                        && w_release) begin
                    n_state = ttds_pkg::ST_PREP;
                    n_axis  = 1'b0;
                end
            end
            ttds_pkg::ST_PREP: begin
                n_diff  = w_raw - w_lo;
                n_span  = w_hi - w_lo;
                n_state = ttds_pkg::ST_ABS;
            end
            ttds_pkg::ST_ABS: begin
                n_neg   = r_diff[VW-1];
                n_mag   = r_diff[VW-1] ? (~r_diff + VW'(1)) : r_diff;
                n_dvs   = (r_span[VW-1] || r_span == '0) ? (VW-1)'(1) : r_span[VW-2:0];
                n_size  = w_size;
                n_acc   = '0;
                n_cnt   = ttds_pkg::MUL_STEPS - CW'(1);
                n_state = ttds_pkg::ST_MUL;
            end
            ttds_pkg::ST_MUL: begin
                n_acc  = {r_acc[PW-2:0], 1'b0} + (r_size[SW-1] ? {{SW{1'b0}}, r_mag} : '0);
                n_size = {r_size[SW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_cnt   = ttds_pkg::DIV_STEPS - CW'(1);
                    n_rem   = '0;
                    n_state = ttds_pkg::ST_DIV;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ttds_pkg::ST_DIV: begin
                n_rem = w_qbit ? w_trial[VW-1:0] : {r_rem[VW-2:0], r_acc[PW-1]};
                n_acc = {r_acc[PW-2:0], w_qbit};
                if (r_cnt == '0) begin
                    n_state = ttds_pkg::ST_FIN;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            ttds_pkg::ST_FIN: begin
                if (r_axis) begin
                    n_qy    = w_q;
                    n_state = ttds_pkg::ST_OUT;
                end else begin
                    n_qx    = w_q;
                    n_axis  = 1'b1;
                    n_state = ttds_pkg::ST_PREP;
                end
            end
            ttds_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = ttds_pkg::ST_IDLE;
                end
            end
            default: n_state = ttds_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ttds_pkg::ST_IDLE;
            r_axis          <= 1'b0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_raw_min_x     <= ttds_pkg::RST_RAW_MIN;
            r_raw_max_x     <= ttds_pkg::RST_RAW_MAX;
            r_raw_min_y     <= ttds_pkg::RST_RAW_MIN;
            r_raw_max_y     <= ttds_pkg::RST_RAW_MAX;
            r_screen_width  <= ttds_pkg::RST_WIDTH;
            r_screen_height <= ttds_pkg::RST_HEIGHT;
            r_last_x        <= '0;
            r_last_y        <= '0;
            r_contact       <= 1'b0;
            r_down_sync     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= w_out_load || (r_out_valid && !m_axis_tready);
            if (w_cfg_wr) begin
                unique case (ttds_pkg::t_reg'(paddr[4:2]))
                    ttds_pkg::REG_RAW_MIN_X:     r_raw_min_x     <= pwdata;
                    ttds_pkg::REG_RAW_MAX_X:     r_raw_max_x     <= pwdata;
                    ttds_pkg::REG_RAW_MIN_Y:     r_raw_min_y     <= pwdata;
                    ttds_pkg::REG_RAW_MAX_Y:     r_raw_max_y     <= pwdata;
                    ttds_pkg::REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[SW-1:0];
                    ttds_pkg::REG_SCREEN_HEIGHT: r_screen_height <= pwdata[SW-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                unique case (ttds_pkg::t_cmd'(s_axis_tuser))
                    ttds_pkg::CMD_POS_X:   r_last_x    <= s_axis_tdata;
                    ttds_pkg::CMD_POS_Y:   r_last_y    <= s_axis_tdata;
                    ttds_pkg::CMD_CONTACT: r_contact   <= !s_axis_tdata[VW-1];
                    ttds_pkg::CMD_BUTTON:  r_contact   <= (s_axis_tdata != '0);
                    ttds_pkg::CMD_SYNC:    r_down_sync <= r_contact;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_span <= n_span;
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_dvs  <= n_dvs;
        r_size <= n_size;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        if (w_out_load) begin
            r_out_x <= r_qx;
            r_out_y <= r_qy;
        end
    end

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ttds_pkg::ST_OUT))
        else $error("tap word raised outside the output state");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttds_pkg::ST_DIV) |-> (r_rem < {1'b0, r_dvs}))
        else $error("divide remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttds_pkg::ST_MUL || r_state == ttds_pkg::ST_DIV) |-> (r_dvs != '0))
        else $error("zero divisor in scaling unit");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttds_pkg::ST_IDLE && w_in_acc && w_release
            && ttds_pkg::t_cmd'(s_axis_tuser) == ttds_pkg::CMD_SYNC)
            |=> (!s_axis_tready && !r_axis))
        else $error("release sync did not start scaling");

endmodule
